### rtl/core/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper package
// Shared types and constants for the bank mapper core.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_PRG_READ  = 2'd1,
    OP_CHR_READ  = 2'd2
  } sbsm_op_e;

  localparam int unsigned BankW    = 5;
  localparam int unsigned CountW   = 6;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned MappedW  = 19;
  localparam int unsigned MirrorW  = 2;

  localparam logic [CountW-1:0] PrgCountReset = 6'd16;
  localparam logic [BankW-1:0]  CtrlReset     = 5'h0c;
  localparam logic [BankW-1:0]  CtrlFixLast   = 5'b01100;

  typedef struct packed {
    logic [1:0]       op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } sbsm_item_t;

  typedef struct packed {
    logic [BankW-1:0]   prg_low;
    logic [BankW-1:0]   prg_high;
    logic [BankW-1:0]   chr_low;
    logic [BankW-1:0]   chr_high;
    logic [MirrorW-1:0] mirror;
  } sbsm_banks_t;

endpackage

### rtl/core/sbsm_req_if.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper request channel
// Valid/ready channel that carries one bus access per transfer.
// ----------------------------------------------------------------------------
interface sbsm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  data;

  modport source (output valid, output op, output addr, output data, input ready);
  modport sink   (input valid, input op, input addr, input data, output ready);
endinterface

### rtl/core/sbsm_rsp_if.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper response channel
// Valid/ready channel that carries one translation result per transfer.
// ----------------------------------------------------------------------------
interface sbsm_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [18:0] mapped_addr;
  logic [1:0]  mirroring;

  modport source (output valid, output accepted, output mapped_addr, output mirroring,
                  input ready);
  modport sink   (input valid, input accepted, input mapped_addr, input mirroring,
                  output ready);
endinterface

### rtl/core/sbsm_regs.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper registers
// Serial load register, mapper registers and the derived bank numbers.
// ----------------------------------------------------------------------------
module sbsm_regs
  import sbsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              step_i,
  input  sbsm_item_t        item_i,
  output sbsm_banks_t       banks_o
);

  logic [CountW-1:0]  count_q;
  logic [BankW-1:0]   shift_q, shift_d;
  logic [2:0]         wcnt_q, wcnt_d;
  logic [BankW-1:0]   ctrl_q, ctrl_d;
  logic [BankW-1:0]   chr0_q, chr0_d;
  logic [BankW-1:0]   chr1_q, chr1_d;
  logic [BankW-1:0]   prg_q, prg_d;
  logic [BankW-1:0]   prg_low_q, prg_low_d;
  logic [BankW-1:0]   prg_high_q, prg_high_d;
  logic [BankW-1:0]   chr_low_q, chr_low_d;
  logic [BankW-1:0]   chr_high_q, chr_high_d;
  logic [MirrorW-1:0] mirror_q, mirror_d;
  logic [BankW-1:0]   shift_new;
  logic [BankW-1:0]   last_bank;
  logic               wr_hit;
  logic               wr_reset;
  logic               wr_commit;

  assign wr_hit    = step_i && (item_i.op == OP_REG_WRITE) && item_i.addr[15];
  assign wr_reset  = wr_hit && item_i.data[7];
  assign wr_commit = wr_hit && !item_i.data[7] && (wcnt_q >= 3'd4);
  assign shift_new = {item_i.data[0], shift_q[BankW-1:1]};
  assign last_bank = BankW'(count_q - CountW'(1));

  always_comb begin
    shift_d    = shift_q;
    wcnt_d     = wcnt_q;
    ctrl_d     = ctrl_q;
    chr0_d     = chr0_q;
    chr1_d     = chr1_q;
    prg_d      = prg_q;
    mirror_d   = mirror_q;
    chr_low_d  = chr_low_q;
    chr_high_d = chr_high_q;
    prg_low_d  = prg_low_q;
    prg_high_d = prg_high_q;

    if (wr_reset) begin
      shift_d = '0;
      wcnt_d  = '0;
      ctrl_d  = ctrl_q | CtrlFixLast;
    end else if (wr_commit) begin
      case (item_i.addr[14:13])
        2'd0:    ctrl_d = shift_new;
        2'd1:    chr0_d = shift_new;
        2'd2:    chr1_d = shift_new;
        default: prg_d  = shift_new;
      endcase
      shift_d  = '0;
      wcnt_d   = '0;
      mirror_d = ctrl_d[1:0];
      if (!ctrl_d[4]) begin
        chr_low_d  = {chr0_d[BankW-1:1], 1'b0};
        chr_high_d = {chr0_d[BankW-1:1], 1'b1};
      end else begin
        chr_low_d  = chr0_d;
        chr_high_d = chr1_d;
      end
    end else if (wr_hit) begin
      shift_d = shift_new;
      wcnt_d  = wcnt_q + 3'd1;
    end

    if (wr_reset || wr_commit) begin
      case (ctrl_d[3:2])
        2'd0, 2'd1: begin
          prg_low_d  = {1'b0, prg_d[3:1], 1'b0};
          prg_high_d = {1'b0, prg_d[3:1], 1'b1};
        end
        2'd2: begin
          prg_low_d  = '0;
          prg_high_d = {1'b0, prg_d[3:0]};
        end
        default: begin
          prg_low_d  = {1'b0, prg_d[3:0]};
          prg_high_d = last_bank;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= PrgCountReset;
      shift_q    <= '0;
      wcnt_q     <= '0;
      ctrl_q     <= CtrlReset;
      chr0_q     <= '0;
      chr1_q     <= '0;
      prg_q      <= '0;
      prg_low_q  <= '0;
      prg_high_q <= BankW'(PrgCountReset - CountW'(1));
      chr_low_q  <= '0;
      chr_high_q <= '0;
      mirror_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      shift_q    <= shift_d;
      wcnt_q     <= wcnt_d;
      ctrl_q     <= ctrl_d;
      chr0_q     <= chr0_d;
      chr1_q     <= chr1_d;
      prg_q      <= prg_d;
      prg_low_q  <= prg_low_d;
      prg_high_q <= prg_high_d;
      chr_low_q  <= chr_low_d;
      chr_high_q <= chr_high_d;
      mirror_q   <= mirror_d;
    end
  end

  assign banks_o = '{prg_low:  prg_low_q,
                     prg_high: prg_high_q,
                     chr_low:  chr_low_q,
                     chr_high: chr_high_q,
                     mirror:   mirror_d};

  // The serial load never holds more than four pending bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wcnt_q <= 3'd4)
    else $error("serial write count overran");

  // A reset write restarts the serial load and selects fix-last program mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   wr_reset |=> (wcnt_q == 3'd0) && (ctrl_q[3:2] == 2'b11))
    else $error("reset write did not take effect");

  // After a completed load the mirroring follows the control register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   wr_commit |=> (wcnt_q == 3'd0) && (mirror_q == ctrl_q[1:0]))
    else $error("completed load left stale state");

endmodule

### rtl/core/sbsm_xlate.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper address translation
// Range check for register writes, and range check and bank substitution for
// program and pattern reads.
module sbsm_xlate
  import sbsm_pkg::*;
(
  input  sbsm_item_t         item_i,
  input  sbsm_banks_t        banks_i,
  output logic               accepted_o,
  output logic [MappedW-1:0] mapped_o
);

  always_comb begin
    accepted_o = 1'b0;
    mapped_o   = '0;
    unique case (item_i.op)
      OP_REG_WRITE: begin
        accepted_o = item_i.addr[15];
      end
      OP_PRG_READ: begin
        if (item_i.addr[15]) begin
          accepted_o = 1'b1;
          mapped_o   = item_i.addr[14] ? {banks_i.prg_high, item_i.addr[13:0]}
                                       : {banks_i.prg_low,  item_i.addr[13:0]};
        end
      end
      OP_CHR_READ: begin
        if (item_i.addr[15:13] == 3'd0) begin
          accepted_o = 1'b1;
          mapped_o   = item_i.addr[12] ? {2'b00, banks_i.chr_high, item_i.addr[11:0]}
                                       : {2'b00, banks_i.chr_low,  item_i.addr[11:0]};
        end
      end
      default: begin
        accepted_o = 1'b0;
        mapped_o   = '0;
      end
    endcase
  end

endmodule

### rtl/core/serial_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// Serial bank switch mapper
// Serially loaded cartridge bank mapper with one result per bus access.
// ----------------------------------------------------------------------------
// Every request transfer produces exactly one response transfer. A request
// is captured in an input register, and when it can move on the register
// update and the address translation are done together into the response
// register, from which the response transfers. A new request can be taken
// every cycle as long as responses are taken as they come. While a finished
// response waits, the input register holds one more request and further
// requests stall until the response transfers. The program bank count is
// written through cfg_we_i and cfg_wdata_i; the user must write it only
// while no request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  sbsm_req_if.sink          req,
  sbsm_rsp_if.source        rsp
);

  sbsm_item_t         item_q;
  logic               in_vld_q;
  logic               out_vld_q;
  logic               advance;
  logic               step;
  sbsm_banks_t        banks;
  logic               accepted;
  logic [MappedW-1:0] mapped;
  logic               acc_q;
  logic [MappedW-1:0] mapped_q;
  logic [MirrorW-1:0] mirror_q;

  assign advance   = !out_vld_q || rsp.ready;
  assign req.ready = !in_vld_q || advance;
  assign step      = in_vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req.ready) begin
        in_vld_q <= req.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      item_q <= '{op: req.op, addr: req.addr, data: req.data};
    end
    if (step) begin
      acc_q    <= accepted;
      mapped_q <= mapped;
      mirror_q <= banks.mirror;
    end
  end

  sbsm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item_q),
    .banks_o     (banks)
  );

  sbsm_xlate u_xlate (
    .item_i     (item_q),
    .banks_i    (banks),
    .accepted_o (accepted),
    .mapped_o   (mapped)
  );

  assign rsp.valid       = out_vld_q;
  assign rsp.accepted    = acc_q;
  assign rsp.mapped_addr = mapped_q;
  assign rsp.mirroring   = mirror_q;

  // A captured request that cannot move on stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_vld_q && !advance) |=> in_vld_q)
    else $error("stalled request was dropped");

  // Processing a request always leaves a response ready to transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) step |=> out_vld_q)
    else $error("processed request produced no response");

  // Writes never carry a translated address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step && (item_q.op == OP_REG_WRITE)) |=> (mapped_q == '0))
    else $error("write produced a translated address");

endmodule
